// ===== rtl/core/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg: shared types for the text character to column bitmap block
// Operation codes, controller states and the command and status groups
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcb_pkg;

  localparam int GLYPHS         = 256;
  localparam int ROWS_PER_GLYPH = 8;
  localparam int MAX_COLS       = 6;
  localparam int ROW_W          = 6;
  localparam int CODE_W         = 8;
  localparam int ADDR_W         = 9;
  localparam int BYTE_W         = 8;
  localparam int COL_W          = 3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_we;
    logic draw_start;
    logic col_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic last_col;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcb_ram.sv =====
// ----------------------------------------------------------------------------
// tcb_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcb_ctrl: controller for the character generator
// Accepts load and draw transactions and steps through the glyph columns.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tcb_pkg::ctl_cmd_t      cmd,
  input  wire tcb_pkg::dp_sts_t  sts
);

  tcb_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = in_valid && (state_r == tcb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcb_pkg::ST_IDLE: begin
        if (accept && (in_op == tcb_pkg::OP_DRAW) && sts.in_grid) begin
          state_nxt = tcb_pkg::ST_EMIT;
        end
      end
      tcb_pkg::ST_EMIT: begin
        if (out_ready && sts.last_col) begin
          state_nxt = tcb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.load_we    = 1'b0;
    cmd.draw_start = 1'b0;
    cmd.col_step   = 1'b0;
    unique case (state_r)
      tcb_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_we    = accept && (in_op == tcb_pkg::OP_LOAD);
        cmd.draw_start = accept && (in_op == tcb_pkg::OP_DRAW) && sts.in_grid;
      end
      tcb_pkg::ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.col_step = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcb_datapath.sv =====
// ----------------------------------------------------------------------------
// tcb_datapath: font store and column byte datapath
// Eight row banks hold the glyphs; a draw reads one glyph at once and
// the column counter turns it into vertical bytes and addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_datapath #(
  parameter int CHAR_COLUMNS = 20,
  parameter int TEXT_ROWS    = 4,
  parameter int LINE_PIXELS  = 122,
  parameter int CELL_WIDTH   = 6,
  parameter int CELL_HEIGHT  = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tcb_pkg::ctl_cmd_t              cmd,
  output tcb_pkg::dp_sts_t                    sts,
  input  wire logic [tcb_pkg::CODE_W-1:0]     in_char_code,
  input  wire logic [2:0]                     in_font_row,
  input  wire logic [tcb_pkg::ROW_W-1:0]      in_row_bits,
  input  wire logic [4:0]                     in_col_x,
  input  wire logic [2:0]                     in_row_y,
  output logic      [tcb_pkg::ADDR_W-1:0]     out_fb_address,
  output logic      [tcb_pkg::BYTE_W-1:0]     out_fb_byte,
  output logic                                out_last
);

  localparam int NCOLS = (CELL_WIDTH > tcb_pkg::MAX_COLS) ? tcb_pkg::MAX_COLS : CELL_WIDTH;

  logic [tcb_pkg::ROW_W-1:0]  glyph_row [tcb_pkg::ROWS_PER_GLYPH];
  logic [tcb_pkg::ADDR_W-1:0] base_addr_r, base_addr_nxt;
  logic [tcb_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcb_pkg::COL_W-1:0]  shift;
  logic [11:0]                y_prod;
  logic [8:0]                 x_prod;

  // eight row banks, one glyph per address
  for (genvar b = 0; b < tcb_pkg::ROWS_PER_GLYPH; b++) begin : g_bank
    tcb_ram #(
      .WIDTH(tcb_pkg::ROW_W),
      .DEPTH(tcb_pkg::GLYPHS)
    ) u_bank (
      .clk    (clk),
      .we     (cmd.load_we && (in_font_row == 3'(b))),
      .wr_addr(in_char_code),
      .wr_data(in_row_bits),
      .re     (cmd.draw_start),
      .rd_addr(in_char_code),
      .rd_data(glyph_row[b])
    );
  end

  assign sts.in_grid = ({1'b0, in_col_x} < 6'(CHAR_COLUMNS)) &&
                       ({1'b0, in_row_y} < 4'(TEXT_ROWS));

  assign y_prod        = 12'(in_row_y) * 12'(LINE_PIXELS);
  assign x_prod        = 9'(in_col_x) * 9'(CELL_WIDTH);
  assign base_addr_nxt = y_prod[8:0] + x_prod;

  always_comb begin
    col_nxt = col_r;
    if (cmd.draw_start) begin
      col_nxt = '0;
    end else if (cmd.col_step) begin
      col_nxt = col_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      base_addr_r <= base_addr_nxt;
    end
  end

  assign shift = 3'(CELL_WIDTH - 1) - col_r;

  always_comb begin
    logic [7:0] padded;
    out_fb_byte = '0;
    for (int r = 0; r < tcb_pkg::ROWS_PER_GLYPH; r++) begin
      padded = {2'b00, glyph_row[r]};
      out_fb_byte[r] = (r < CELL_HEIGHT) ? padded[shift] : 1'b0;
    end
  end

  assign sts.last_col     = (col_r == 3'(NCOLS - 1));
  assign out_last         = sts.last_col;
  assign out_fb_address   = base_addr_r + 9'(col_r);

endmodule

`default_nettype wire

// ===== rtl/core/text_char_to_column_bitmap.sv =====
// ----------------------------------------------------------------------------
// text_char_to_column_bitmap: character generator with programmable font
// Input channel (in_*): a load transaction (in_op = 0) writes one 6-bit
// row of one glyph into the font store; a draw transaction (in_op = 1)
// renders a stored glyph at text position in_col_x, in_row_y.
// Output channel (out_*): one framebuffer write per glyph column, left to
// right, address row_y*LINE_PIXELS + col_x*CELL_WIDTH + column modulo 512,
// out_last high on the final column. Draws outside the grid emit nothing.
// The first column appears the cycle after the draw is accepted; a load
// writes the font store as it is accepted. A draw occupies the block,
// accepting no other transaction, until its final column is taken; the
// single column counter walks the glyph read from the eight row banks.
// While out_ready is low the current column holds and no new transaction
// is accepted. Reset returns the controller to idle; the font store is
// not cleared, so a glyph must be loaded before it is drawn.
// ----------------------------------------------------------------------------
`default_nettype none

module text_char_to_column_bitmap #(
  parameter int CHAR_COLUMNS = 20,
  parameter int TEXT_ROWS    = 4,
  parameter int LINE_PIXELS  = 122,
  parameter int CELL_WIDTH   = 6,
  parameter int CELL_HEIGHT  = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_op,
  input  wire logic [tcb_pkg::CODE_W-1:0] in_char_code,
  input  wire logic [2:0]                 in_font_row,
  input  wire logic [tcb_pkg::ROW_W-1:0]  in_row_bits,
  input  wire logic [4:0]                 in_col_x,
  input  wire logic [2:0]                 in_row_y,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [tcb_pkg::ADDR_W-1:0]      out_fb_address,
  output logic [tcb_pkg::BYTE_W-1:0]      out_fb_byte,
  output logic                            out_last
);

  tcb_pkg::ctl_cmd_t cmd;
  tcb_pkg::dp_sts_t  sts;

  tcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tcb_datapath #(
    .CHAR_COLUMNS(CHAR_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS),
    .LINE_PIXELS (LINE_PIXELS),
    .CELL_WIDTH  (CELL_WIDTH),
    .CELL_HEIGHT (CELL_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_char_code  (in_char_code),
    .in_font_row   (in_font_row),
    .in_row_bits   (in_row_bits),
    .in_col_x      (in_col_x),
    .in_row_y      (in_row_y),
    .out_fb_address(out_fb_address),
    .out_fb_byte   (out_fb_byte),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== tb/text_char_to_column_bitmap_test.sv =====
// ----------------------------------------------------------------------------
// text_char_to_column_bitmap_test: self-checking bench for the glyph renderer
// Loads glyph rows into the font store and draws glyphs at text positions.
// Directed rows come first, then random load bursts, row rewrites and draws
// inside and outside the grid. Each column write is checked against a local
// model of the font store and the framebuffer address math. Both channels
// idle at random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_char_to_column_bitmap_test;

  localparam int CHAR_COLUMNS = 20;
  localparam int TEXT_ROWS    = 4;
  localparam int LINE_PIXELS  = 122;
  localparam int CELL_WIDTH   = 6;
  localparam int CELL_HEIGHT  = 8;
  localparam int DIRECTED_N   = 25;
  localparam int RANDOM_ITEMS = 325;
  localparam int LONG_HOLD    = 200;

  typedef struct {
    tcb_pkg::op_t op;
    logic [7:0]   char_code;
    logic [2:0]   font_row;
    logic [5:0]   row_bits;
    logic [4:0]   col_x;
    logic [2:0]   row_y;
    bit           typed;
    int           typed_cols;
    logic [8:0]   typed_addr;
    logic [7:0]   typed_col;
  } char_item_t;

  typedef struct {
    logic [8:0] fb_address;
    logic [7:0] fb_col;
    logic       last;
  } fb_write_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_op;
  logic [7:0] in_char_code;
  logic [2:0] in_font_row;
  logic [5:0] in_row_bits;
  logic [4:0] in_col_x;
  logic [2:0] in_row_y;
  logic       out_valid;
  logic       out_ready;
  logic [8:0] out_fb_address;
  logic [7:0] out_fb_byte;
  logic       out_last;

  logic [5:0] glyph_rows [0:2047];
  logic [7:0] rows_written [0:255];
  bit         glyph_ready [0:255];
  int         ready_codes [$];
  fb_write_t  pending_writes [$];
  char_item_t directed_rows [DIRECTED_N];
  int         error_count;
  int         accepted_items;
  bit         calm_phase;
  bit         long_hold_done;

  text_char_to_column_bitmap #(
    .CHAR_COLUMNS(CHAR_COLUMNS),
    .TEXT_ROWS(TEXT_ROWS),
    .LINE_PIXELS(LINE_PIXELS),
    .CELL_WIDTH(CELL_WIDTH),
    .CELL_HEIGHT(CELL_HEIGHT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_char_code(in_char_code),
    .in_font_row(in_font_row),
    .in_row_bits(in_row_bits),
    .in_col_x(in_col_x),
    .in_row_y(in_row_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_fb_address(out_fb_address),
    .out_fb_byte(out_fb_byte),
    .out_last(out_last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] expv,
                                 input logic [31:0] gotv);
    $display("mismatch %s: expected %0h got %0h at %0t", what, expv, gotv, $realtime);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic char_item_t mk_item(input tcb_pkg::op_t op, input logic [7:0] code,
                                         input logic [2:0] frow, input logic [5:0] bits,
                                         input logic [4:0] x, input logic [2:0] y,
                                         input bit typed, input int cols,
                                         input logic [8:0] addr, input logic [7:0] col);
    char_item_t it;
    it.op = op;
    it.char_code = code;
    it.font_row = frow;
    it.row_bits = bits;
    it.col_x = x;
    it.row_y = y;
    it.typed = typed;
    it.typed_cols = cols;
    it.typed_addr = addr;
    it.typed_col = col;
    return it;
  endfunction

  function automatic char_item_t random_item(input tcb_pkg::op_t op);
    return mk_item(op, 8'($urandom), 3'($urandom), 6'($urandom), 5'($urandom),
                   3'($urandom), 1'b0, 0, '0, '0);
  endfunction

  // column c of a glyph: bit r is the pixel of row r at bit (5 - c)
  function automatic logic [7:0] glyph_column(input logic [7:0] code, input int c);
    logic [7:0] col;
    logic [5:0] bits;
    col = '0;
    for (int r = 0; r < CELL_HEIGHT && r < 8; r++) begin
      bits = glyph_rows[{code, 3'(r)}];
      col[r] = bits[CELL_WIDTH - 1 - c];
    end
    return col;
  endfunction

  task automatic render_char_item(input char_item_t it);
    fb_write_t w;
    int ncols;
    ncols = (CELL_WIDTH > tcb_pkg::MAX_COLS) ? tcb_pkg::MAX_COLS : CELL_WIDTH;
    if (it.op == tcb_pkg::OP_LOAD) begin
      glyph_rows[{it.char_code, it.font_row}] = it.row_bits;
      rows_written[it.char_code][it.font_row] = 1'b1;
      if (rows_written[it.char_code] == 8'hFF && !glyph_ready[it.char_code]) begin
        glyph_ready[it.char_code] = 1'b1;
        ready_codes.push_back(int'(it.char_code));
      end
    end else if (it.typed) begin
      for (int c = 0; c < it.typed_cols; c++) begin
        w.fb_address = it.typed_addr + 9'(c);
        w.fb_col = it.typed_col;
        w.last = (c == it.typed_cols - 1);
        pending_writes.push_back(w);
      end
    end else if (it.col_x < CHAR_COLUMNS && it.row_y < TEXT_ROWS) begin
      for (int c = 0; c < ncols; c++) begin
        w.fb_address = 9'(it.row_y * LINE_PIXELS + it.col_x * CELL_WIDTH + c);
        w.fb_col = glyph_column(it.char_code, c);
        w.last = (c == ncols - 1);
        pending_writes.push_back(w);
      end
    end
  endtask

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_char_item(input char_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = it.op;
    in_char_code = it.char_code;
    in_font_row = it.font_row;
    in_row_bits = it.row_bits;
    in_col_x = it.col_x;
    in_row_y = it.row_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    render_char_item(it);
    accepted_items++;
    @(negedge clk);
  endtask

  task automatic load_whole_glyph(input logic [7:0] code);
    char_item_t it;
    for (int r = 0; r < 8; r++) begin
      it = random_item(tcb_pkg::OP_LOAD);
      it.char_code = code;
      it.font_row = 3'(r);
      send_char_item(it);
    end
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    int gap;
    hold_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && accepted_items >= 100) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        gap = pick_gap();
        out_ready = (gap == 0);
        hold_left = (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    fb_write_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected write, address", '0, 32'(out_fb_address));
      end else begin
        w = pending_writes.pop_front();
        if (out_fb_address !== w.fb_address)
          report_mismatch("fb_address", 32'(w.fb_address), 32'(out_fb_address));
        if (out_fb_byte !== w.fb_col)
          report_mismatch("fb_byte", 32'(w.fb_col), 32'(out_fb_byte));
        if (out_last !== w.last)
          report_mismatch("last", 32'(w.last), 32'(out_last));
      end
    end
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    char_item_t it;
    int pick;
    error_count = 0;
    accepted_items = 0;
    calm_phase = 1'b0;
    long_hold_done = 1'b0;
    for (int g = 0; g < 256; g++) begin
      rows_written[g] = '0;
      glyph_ready[g] = 1'b0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = tcb_pkg::OP_LOAD;
    in_char_code = '0;
    in_font_row = '0;
    in_row_bits = '0;
    in_col_x = '0;
    in_row_y = '0;

    // glyph 0 blank, glyph 255 solid
    for (int r = 0; r < 8; r++) begin
      directed_rows[r] = mk_item(tcb_pkg::OP_LOAD, 8'd0, 3'(r), 6'd0, 5'd31, 3'd7,
                                 1'b0, 0, '0, '0);
      directed_rows[8 + r] = mk_item(tcb_pkg::OP_LOAD, 8'd255, 3'(r), 6'd63, 5'd0, 3'd0,
                                     1'b0, 0, '0, '0);
    end
    directed_rows[16] = mk_item(tcb_pkg::OP_DRAW, 8'd255, 3'd0, 6'd0, 5'd0, 3'd0,
                                1'b1, 6, 9'd0, 8'hFF);
    directed_rows[17] = mk_item(tcb_pkg::OP_DRAW, 8'd0, 3'd7, 6'd63, 5'd19, 3'd3,
                                1'b1, 6, 9'd480, 8'h00);
    directed_rows[18] = mk_item(tcb_pkg::OP_DRAW, 8'd255, 3'd0, 6'd0, 5'd19, 3'd3,
                                1'b1, 6, 9'd480, 8'hFF);
    directed_rows[19] = mk_item(tcb_pkg::OP_DRAW, 8'd255, 3'd0, 6'd0, 5'd20, 3'd0,
                                1'b1, 0, '0, '0);
    directed_rows[20] = mk_item(tcb_pkg::OP_DRAW, 8'd255, 3'd0, 6'd0, 5'd0, 3'd4,
                                1'b1, 0, '0, '0);
    directed_rows[21] = mk_item(tcb_pkg::OP_DRAW, 8'd0, 3'd0, 6'd0, 5'd31, 3'd7,
                                1'b1, 0, '0, '0);
    directed_rows[22] = mk_item(tcb_pkg::OP_LOAD, 8'd255, 3'd3, 6'b101010, 5'd5, 3'd2,
                                1'b0, 0, '0, '0);
    directed_rows[23] = mk_item(tcb_pkg::OP_DRAW, 8'd255, 3'd0, 6'd0, 5'd7, 3'd2,
                                1'b0, 0, '0, '0);
    directed_rows[24] = mk_item(tcb_pkg::OP_DRAW, 8'd255, 3'd0, 6'd0, 5'd19, 3'd0,
                                1'b0, 0, '0, '0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) send_char_item(directed_rows[i]);

    while (accepted_items < DIRECTED_N + RANDOM_ITEMS) begin
      calm_phase = ((accepted_items % 64) < 12);
      pick = $urandom_range(0, 99);
      if (pick < 25 || ready_codes.size() == 0) begin
        load_whole_glyph(8'($urandom));
      end else if (pick < 40) begin
        send_char_item(random_item(tcb_pkg::OP_LOAD));
      end else if (pick < 50) begin
        it = random_item(tcb_pkg::OP_DRAW);
        if ($urandom_range(0, 1)) it.col_x = 5'($urandom_range(CHAR_COLUMNS, 31));
        else it.row_y = 3'($urandom_range(TEXT_ROWS, 7));
        send_char_item(it);
      end else begin
        it = random_item(tcb_pkg::OP_DRAW);
        it.char_code = 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
        it.col_x = 5'($urandom_range(0, CHAR_COLUMNS - 1));
        it.row_y = 3'($urandom_range(0, TEXT_ROWS - 1));
        send_char_item(it);
      end
    end
    in_valid = 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tcb_pkg.sv
rtl/core/tcb_ram.sv
rtl/core/tcb_ctrl.sv
rtl/core/tcb_datapath.sv
rtl/core/text_char_to_column_bitmap.sv
tb/text_char_to_column_bitmap_test.sv
